[hdl/ors_pkg.sv]
package ors_pkg;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	localparam logic [7:0] STOP_CODE = 8'd65;
	localparam logic [7:0] REV_PRIO = 8'd66;
	localparam logic [7:0] CRUISE_PRIO = 8'd81;
	localparam logic [9:0] PIVOT_SPEED_RST = 10'd60;

	localparam logic [5:0] BACKUP_TICKS_RST = 6'd11;
	localparam logic [5:0] PIVOT_TICKS_RST = 6'd33;
	localparam logic [5:0] HORN_AFTER_RST = 6'd10;
	localparam logic [5:0] BACKUP_AFTER_RST = 6'd20;
	localparam logic [9:0] BACKUP_SPEED_RST = 10'd55;
	localparam logic [9:0] CRUISE_SPEED_RST = 10'd50;

	typedef enum logic [2:0] {
		REG_BACKUP_TICKS = 3'd0,
		REG_PIVOT_TICKS = 3'd1,
		REG_HORN_AFTER = 3'd2,
		REG_BACKUP_AFTER = 3'd3,
		REG_BACKUP_SPEED = 3'd4,
		REG_CRUISE_SPEED = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [5:0] backup_ticks;
		logic [5:0] pivot_ticks;
		logic [5:0] horn_after;
		logic [5:0] backup_after;
		logic [9:0] backup_speed;
		logic [9:0] cruise_speed;
	} cfg_t;

	typedef struct packed {
		logic present;
		logic [7:0] prio;
		logic stale;
		logic lrev;
		logic [9:0] lspd;
		logic rrev;
		logic [9:0] rspd;
	} msg_t;

	typedef struct packed {
		logic kind;
		logic horn;
		logic [7:0] prio;
		logic lrev;
		logic [9:0] lspd;
		logic rrev;
		logic [9:0] rspd;
		logic last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t r0;
		res_t r1;
	} push_t;

	localparam msg_t MSG_EMPTY = '0;
	localparam msg_t PIVOT_RST = '{present: 1'b1, prio: REV_PRIO, stale: 1'b0,
		lrev: 1'b0, lspd: PIVOT_SPEED_RST, rrev: 1'b1, rspd: PIVOT_SPEED_RST};
	localparam res_t RES_NONE = '0;

	function automatic res_t res_of_msg(msg_t m);
		res_t r;
		r = RES_NONE;
		r.kind = 1'b1;
		r.prio = m.prio;
		r.lrev = m.lrev;
		r.lspd = m.lspd;
		r.rrev = m.rrev;
		r.rspd = m.rspd;
		return r;
	endfunction

	function automatic res_t res_drive(logic [7:0] prio, logic rev, logic [9:0] spd);
		res_t r;
		r = RES_NONE;
		r.kind = 1'b1;
		r.prio = prio;
		r.lrev = rev;
		r.lspd = spd;
		r.rrev = rev;
		r.rspd = spd;
		return r;
	endfunction

endpackage

[hdl/obstacle_recovery_sequencer.sv]
// Flow: an accepted beat is held in the input stage register; once the result queue has
// room it is processed and its results are pushed into the queue, from which they are read.
// Throughput: one input beat per cycle while each gives one result and the output is taken.
// Steps that give two results fill the queue faster than the single output port drains
// it; the input stalls while the four-entry result queue holds more than two results.
// Reset: arst_n clears the stored messages, counters, flags and the result queue at once
// and loads the default configuration and the default right pivot command.
module obstacle_recovery_sequencer (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// present, priority_req[7:0], stale, left_reverse, left_speed[9:0],
	// right_reverse, right_speed[9:0]
	input  logic [ors_pkg::DATA_W-1:0] s_axis_tdata,
	// mode
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// horn, cmd_priority[7:0], cmd_left_reverse, cmd_left_speed[9:0],
	// cmd_right_reverse, cmd_right_speed[9:0], one zero bit
	output logic [ors_pkg::DATA_W-1:0] m_axis_tdata,
	// kind
	output logic m_axis_tuser,
	output logic m_axis_tlast,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ors_pkg::ADDR_W-1:0] paddr,
	input  logic [ors_pkg::DATA_W-1:0] pwdata,
	output logic [ors_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import ors_pkg::*;

	cfg_t cfg;
	push_t push;
	logic room;
	res_t res;

	ors_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	ors_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_mode(s_axis_tuser),
		.in_data(s_axis_tdata),
		.cfg(cfg),
		.room(room),
		.push(push)
	);

	ors_res_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res(res)
	);

	assign m_axis_tdata = {1'b0, res.rspd, res.rrev, res.lspd, res.lrev, res.prio, res.horn};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

[hdl/ors_cfg_regs.sv]
module ors_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ors_pkg::ADDR_W-1:0] paddr,
	input  logic [ors_pkg::DATA_W-1:0] pwdata,
	output logic [ors_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output ors_pkg::cfg_t cfg
);
	import ors_pkg::*;

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backup_ticks <= BACKUP_TICKS_RST;
			cfg_q.pivot_ticks <= PIVOT_TICKS_RST;
			cfg_q.horn_after <= HORN_AFTER_RST;
			cfg_q.backup_after <= BACKUP_AFTER_RST;
			cfg_q.backup_speed <= BACKUP_SPEED_RST;
			cfg_q.cruise_speed <= CRUISE_SPEED_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_BACKUP_TICKS: cfg_q.backup_ticks <= pwdata[5:0];
				REG_PIVOT_TICKS: cfg_q.pivot_ticks <= pwdata[5:0];
				REG_HORN_AFTER: cfg_q.horn_after <= pwdata[5:0];
				REG_BACKUP_AFTER: cfg_q.backup_after <= pwdata[5:0];
				REG_BACKUP_SPEED: cfg_q.backup_speed <= pwdata[9:0];
				REG_CRUISE_SPEED: cfg_q.cruise_speed <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BACKUP_TICKS: prdata = {26'd0, cfg_q.backup_ticks};
			REG_PIVOT_TICKS: prdata = {26'd0, cfg_q.pivot_ticks};
			REG_HORN_AFTER: prdata = {26'd0, cfg_q.horn_after};
			REG_BACKUP_AFTER: prdata = {26'd0, cfg_q.backup_after};
			REG_BACKUP_SPEED: prdata = {22'd0, cfg_q.backup_speed};
			REG_CRUISE_SPEED: prdata = {22'd0, cfg_q.cruise_speed};
			default: prdata = '0;
		endcase
	end

endmodule

[hdl/ors_core.sv]
module ors_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_mode,
	input  logic [ors_pkg::DATA_W-1:0] in_data,
	input  ors_pkg::cfg_t cfg,
	input  logic room,
	output ors_pkg::push_t push
);
	import ors_pkg::*;

	logic valid_s1;
	logic mode_s1;
	msg_t msg_s1;
	msg_t in_msg;
	logic fire;

	msg_t sensor_q, camera_q, saved_q;
	logic [5:0] step_q, stale_q;
	logic backing_q, pivoting_q, hold_q;

	msg_t sens, cam, pick, sav;
	logic [6:0] step, stale;
	logic bk, pv, hold, horn;
	logic [1:0] n;
	res_t r0, r1;

	always_comb begin
		in_msg = MSG_EMPTY;
		if (in_data[0]) begin
			in_msg.present = 1'b1;
			in_msg.prio = in_data[8:1];
			in_msg.stale = in_mode & in_data[9];
			in_msg.lrev = in_data[10];
			in_msg.lspd = in_data[20:11];
			in_msg.rrev = in_data[21];
			in_msg.rspd = in_data[31:22];
		end
	end

	assign fire = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= in_mode;
			msg_s1 <= in_msg;
		end
	end

	// Results are collected in order; n counts how many this beat produces.
	always_comb begin
		sens = mode_s1 ? sensor_q : msg_s1;
		cam = mode_s1 ? msg_s1 : camera_q;
		step = {1'b0, step_q};
		stale = {1'b0, stale_q};
		bk = backing_q;
		pv = pivoting_q;
		hold = hold_q;
		sav = saved_q;
		horn = 1'b0;
		n = 2'd0;
		r0 = RES_NONE;
		r1 = RES_NONE;
		pick = cam;
		if (!sens.present && !cam.present) begin
			if (!mode_s1) begin
				r0 = res_drive(CRUISE_PRIO, 1'b0, cfg.cruise_speed);
			end
			n = 2'd1;
		end else begin
			if (!sens.present) begin
				pick = cam;
			end else if (!cam.present) begin
				pick = sens;
			end else if (sens.prio < cam.prio) begin
				pick = sens;
			end else begin
				pick = cam;
			end
			if (sens.present && sens.prio == STOP_CODE) begin
				if (!hold) begin
					bk = 1'b0;
					pv = 1'b0;
					hold = 1'b1;
					step = '0;
					r0 = res_of_msg(sens);
					n = 2'd1;
				end else begin
					if (cam.present && cam.stale) begin
						stale = stale + 7'd1;
					end else begin
						stale = '0;
					end
					if (stale > {1'b0, cfg.backup_after}) begin
						bk = 1'b1;
						pv = 1'b0;
					end else if (stale > {1'b0, cfg.horn_after}) begin
						horn = 1'b1;
					end else if (!bk) begin
						step = '0;
					end
					if (bk) begin
						step = step + 7'd1;
						stale = '0;
						if (step > {1'b0, cfg.backup_ticks}) begin
							step = '0;
							bk = 1'b0;
							pv = 1'b1;
						end else begin
							r0 = res_drive(REV_PRIO, 1'b1, cfg.backup_speed);
							n = 2'd1;
						end
					end
					if (pv) begin
						step = step + 7'd1;
						r0 = res_of_msg(sav);
						n = 2'd1;
						stale = '0;
						if (step > {1'b0, cfg.pivot_ticks}) begin
							step = '0;
							bk = 1'b0;
							pv = 1'b0;
							hold = 1'b0;
						end
					end
					if (!(bk || pv)) begin
						if (n == 2'd0) begin
							r0 = res_of_msg(sens);
						end else begin
							r1 = res_of_msg(sens);
						end
						n = n + 2'd1;
					end
				end
			end else begin
				hold = 1'b0;
				stale = '0;
				if (bk) begin
					step = step + 7'd1;
					if (step > {1'b0, cfg.backup_ticks}) begin
						step = '0;
						bk = 1'b0;
						pv = 1'b1;
					end else begin
						r0 = res_drive(REV_PRIO, 1'b1, cfg.backup_speed);
						n = 2'd1;
					end
				end
				if (pv) begin
					step = step + 7'd1;
					r0 = res_of_msg(sav);
					n = 2'd1;
					if (step > {1'b0, cfg.pivot_ticks}) begin
						step = '0;
						bk = 1'b0;
						pv = 1'b0;
					end
				end
				if (!(bk || pv)) begin
					if (pick.lrev != pick.rrev) begin
						bk = 1'b1;
						sav = pick;
						if (n == 2'd0) begin
							r0 = res_drive(REV_PRIO, 1'b1, cfg.backup_speed);
						end else begin
							r1 = res_drive(REV_PRIO, 1'b1, cfg.backup_speed);
						end
					end else begin
						if (n == 2'd0) begin
							r0 = res_of_msg(pick);
						end else begin
							r1 = res_of_msg(pick);
						end
					end
					n = n + 2'd1;
				end
			end
		end
		r0.horn = horn;
		r1.horn = horn;
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end else begin
			r0.last = 1'b1;
		end
		push.cnt = fire ? n : 2'd0;
		push.r0 = r0;
		push.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_q <= MSG_EMPTY;
			camera_q <= MSG_EMPTY;
			saved_q <= PIVOT_RST;
			step_q <= '0;
			stale_q <= '0;
			backing_q <= 1'b0;
			pivoting_q <= 1'b0;
			hold_q <= 1'b0;
		end else if (fire) begin
			sensor_q <= sens;
			camera_q <= cam;
			saved_q <= sav;
			step_q <= step[5:0];
			stale_q <= stale[5:0];
			backing_q <= bk;
			pivoting_q <= pv;
			hold_q <= hold;
		end
	end

endmodule

[hdl/ors_res_fifo.sv]
module ors_res_fifo (
	input  logic clk,
	input  logic arst_n,
	input  ors_pkg::push_t push,
	output logic room,
	output logic out_valid,
	input  logic out_ready,
	output ors_pkg::res_t out_res
);
	import ors_pkg::*;

	res_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0] cnt_q;
	logic pop;

	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && out_ready;
	assign room = (cnt_q <= (PTR_W+1)'(DEPTH - 2));
	assign out_res = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + PTR_W'(push.cnt);
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push.cnt) - (PTR_W+1)'(pop);
		end
	end

endmodule
